>>> hw/rtl/weighted_connection_share_arbiter_top_defines.svh
// ----------------------------------------------------------------------------
// Weighted connection share arbiter: assertion macros
// Shared property forms used by the checker of the arbiter.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_CONNECTION_SHARE_ARBITER_TOP_DEFINES_SVH
`define WEIGHTED_CONNECTION_SHARE_ARBITER_TOP_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define WCSA_CHECK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wcsa check failed");

// The consequent must hold in the same cycle as the antecedent.
`define WCSA_CHECK_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wcsa check failed");

`endif

>>> hw/rtl/wcsa_pkg.sv
// ----------------------------------------------------------------------------
// Weighted connection share arbiter package
// Operation and status codes, the user entry record and the sequencer states.
// ----------------------------------------------------------------------------
package wcsa_pkg;

  // Operation codes carried by a request.
  typedef enum logic [2:0] {
    OP_ADD         = 3'd0,
    OP_SET_WEIGHT  = 3'd1,
    OP_REMOVE      = 3'd2,
    OP_ADJUST_WAIT = 3'd3,
    OP_STARTED     = 3'd4,
    OP_FINISHED    = 3'd5,
    OP_REFUSED     = 3'd6,
    OP_QUERY       = 3'd7
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_USER  = 2'd1,
    ST_FULL     = 2'd2,
    ST_DECLINED = 2'd3
  } status_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_INITIAL_BUDGET = 1'b0,
    CFG_STAGGER        = 1'b1
  } cfg_idx_t;

  localparam logic [7:0] RESET_BUDGET = 8'd12;
  // Rank counter width: at most 63 users can stand ahead of another.
  localparam int RANK_W = 6;

  // One user entry as held in a cell, with its per-request scratch fields.
  typedef struct packed {
    logic [7:0]        id;
    logic [7:0]        weight;
    logic [7:0]        active;
    logic [15:0]       waiting;
    logic [RANK_W-1:0] ahead;
    logic [7:0]        quot;
    logic              passed;
  } entry_t;

  // Controls common to every cell.
  typedef struct packed {
    logic rank_en;
    logic rank_clr;
  } cell_ctl_t;

  // Head entry weight broadcast to all cells during the ranking pass.
  typedef struct packed {
    logic       valid;
    logic [7:0] weight;
  } head_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_RANK_CLR,
    S_RANK,
    S_DIV_MUL,
    S_DIV_GO,
    S_DIV_RUN,
    S_REMAIN,
    S_FINAL,
    S_OUT
  } state_t;

endpackage

>>> hw/rtl/wcsa_cell.sv
// ----------------------------------------------------------------------------
// Weighted connection share arbiter cell
// Holds one user entry and hands it to its neighbour when the ring shifts.
// ----------------------------------------------------------------------------
module wcsa_cell import wcsa_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  head_t     head,
  input  logic      at_head,
  input  logic      shift_en,
  input  entry_t    nbr_in,
  output entry_t    pass_out,
  output entry_t    cur_out
);

  entry_t ent_r;
  entry_t ent_nxt;
  logic   inc;

  // The head entry stands ahead of this one if heavier, or equal and older.
  always_comb begin
    inc = head.valid &&
          ((head.weight > ent_r.weight) ||
           ((head.weight == ent_r.weight) && !ent_r.passed && !at_head));
    pass_out = ent_r;
    if (ctl.rank_en) begin
      pass_out.ahead  = ent_r.ahead + RANK_W'(inc);
      pass_out.passed = ent_r.passed | at_head;
    end
  end

  // Entry update: clear the rank scratch, take the neighbour, or hold.
  always_comb begin
    ent_nxt = ent_r;
    if (ctl.rank_clr) begin
      ent_nxt.ahead  = '0;
      ent_nxt.passed = 1'b0;
    end else if (shift_en) begin
      ent_nxt = nbr_in;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign cur_out = ent_r;

endmodule

>>> hw/rtl/wcsa_div.sv
// ----------------------------------------------------------------------------
// Weighted connection share arbiter divider
// Restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wcsa_div #(
  parameter int NW = 16,
  parameter int DW = 14
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic [NW-1:0] quotient,
  output logic          done
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [DW-1:0]    rem_r, rem_nxt;
  logic [NW-1:0]    quo_r, quo_nxt;
  logic [DW-1:0]    div_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DW:0]      trial;
  logic [DW:0]      diff;

  // One restoring step: bring in the next dividend bit and try the subtract.
  always_comb begin
    trial   = {rem_r, quo_r[NW-1]};
    diff    = trial - {1'b0, div_r};
    quo_nxt = {quo_r[NW-2:0], 1'b0};
    rem_nxt = trial[DW-1:0];
    if (trial >= {1'b0, div_r}) begin
      rem_nxt    = diff[DW-1:0];
      quo_nxt[0] = 1'b1;
    end
  end

  // Control: count the steps and flag completion for one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: operands load on start, then one step per busy cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

>>> hw/rtl/weighted_connection_share_arbiter_top.sv
// ----------------------------------------------------------------------------
// Weighted connection share arbiter
// Ordered user table in a ring of cells, with weighted largest-remainder
// shares, start admission and yield advice for the user of each request.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  in      | in_valid, in_stall  | in_op, in_user_id, in_weight, in_waiting_delta, in_now
//  out     | out_valid, out_stall| out_status .. out_user_total
//  cfg     | cfg_we              | cfg_index, cfg_data
//
// A request makes four turns of the cell ring after acceptance; in the division
// turn each user in the table holds the ring for a 16-step division.
// One request is worked on at a time; the next is taken while a result waits.
// A stalled result holds in the output register; the sequencer then waits.
// Reset is synchronous; the table reads as empty and the budget as 12.
// ----------------------------------------------------------------------------
module weighted_connection_share_arbiter_top import wcsa_pkg::*; #(
  parameter int MAX_USERS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [7:0]  in_user_id,
  input  logic [7:0]  in_weight,
  input  logic signed [7:0] in_waiting_delta,
  input  logic [47:0] in_now,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [7:0]  out_user_share,
  output logic [7:0]  out_user_active,
  output logic [11:0] out_all_active,
  output logic [7:0]  out_current_budget,
  output logic        out_start_allowed,
  output logic        out_yield_advised,
  output logic [47:0] out_earliest_start,
  output logic [4:0]  out_user_total,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IW = $clog2(MAX_USERS);
  localparam int CW = $clog2(MAX_USERS + 1);
  localparam int TW = $clog2(MAX_USERS * 255 + 1);

  state_t state_r, state_nxt;

  // Ring of cells.
  entry_t    pass_arr [MAX_USERS];
  entry_t    cur_arr  [MAX_USERS];
  logic      shift_vec [MAX_USERS];
  entry_t    feed;
  cell_ctl_t ctl;
  head_t     hbc;
  logic      ring_shift;
  logic      compact;

  // Request and table state.
  logic [IW-1:0]   k_r;
  logic [CW-1:0]   count_r;
  logic [7:0]      budget_r;
  logic [31:0]     stagger_r;
  logic [47:0]     last_time_r;
  logic            seen_r;
  op_t             op_r;
  logic [7:0]      id_r;
  logic [7:0]      wt_r;
  logic [7:0]      delta_r;
  logic [47:0]     now_r;
  logic            found_r;
  logic [IW-1:0]   idx_r;
  logic            add_done_r;
  logic [TW-1:0]   actsum_r;
  status_t         status_r;
  logic [TW-1:0]   tsum_r;
  logic            found2_r;
  logic [IW-1:0]   idx2_r;
  logic [8:0]      given_r;
  logic [8:0]      rem_r;
  logic [7:0]      usr_share_r;
  logic [7:0]      usr_act_r;
  logic            starved_r;
  logic [15:0]     prod_r;

  // Divider.
  logic            div_start;
  logic [15:0]     div_quot;
  logic            div_done;

  // Output register.
  logic            out_valid_r;
  status_t         o_status_r;
  logic [7:0]      o_share_r;
  logic [7:0]      o_active_r;
  logic [11:0]     o_all_r;
  logic [7:0]      o_budget_r;
  logic            o_allowed_r;
  logic            o_yield_r;
  logic [47:0]     o_earliest_r;
  logic [4:0]      o_total_r;

  // Combinational helpers.
  entry_t          head;
  entry_t          head_mod;
  logic            k_valid;
  logic            k_last;
  logic            scan_hit;
  logic            add_here;
  logic signed [17:0] wsum;
  logic [8:0]      sh9;
  logic [7:0]      head_share;
  logic            out_free;
  logic [TW-1:0]   cap;
  logic            too_soon;
  logic [48:0]     e49;
  logic [47:0]     esat;
  logic [47:0]     earliest;
  logic            allowed;
  logic            yld;

  assign head     = cur_arr[0];
  assign k_valid  = CW'(k_r) < count_r;
  assign k_last   = k_r == IW'(MAX_USERS - 1);
  assign out_free = !out_valid_r || !out_stall;

  // Cell row: each cell takes its upper neighbour, the last takes the feed.
  for (genvar c = 0; c < MAX_USERS; c++) begin : g_cell
    entry_t nbr;
    if (c == MAX_USERS - 1) begin : g_tail
      assign nbr = feed;
      assign shift_vec[c] = ring_shift;
    end else begin : g_body
      assign nbr = pass_arr[c + 1];
      assign shift_vec[c] = ring_shift || (compact && (IW'(c) >= idx_r));
    end
    wcsa_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .head     (hbc),
      .at_head  (c == 0),
      .shift_en (shift_vec[c]),
      .nbr_in   (nbr),
      .pass_out (pass_arr[c]),
      .cur_out  (cur_arr[c])
    );
  end

  wcsa_div #(.NW(16), .DW(TW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (tsum_r),
    .quotient (div_quot),
    .done     (div_done)
  );

  // Head update during the table scan.
  always_comb begin
    scan_hit = k_valid && (head.id == id_r) && !found_r;
    add_here = (op_r == OP_ADD) && !found_r && (CW'(k_r) == count_r);
    wsum     = $signed({2'b00, head.waiting}) + $signed({{10{delta_r[7]}}, delta_r});
    head_mod = head;
    if (scan_hit) begin
      case (op_r)
        OP_SET_WEIGHT: head_mod.weight = wt_r;
        OP_ADJUST_WAIT: begin
          if (wsum < 0) head_mod.waiting = '0;
          else if (wsum > 18'sd65535) head_mod.waiting = 16'hFFFF;
          else head_mod.waiting = wsum[15:0];
        end
        OP_STARTED: begin
          if (head.active != 8'hFF) head_mod.active = head.active + 8'd1;
        end
        OP_FINISHED: begin
          if (head.active != 8'h00) head_mod.active = head.active - 8'd1;
        end
        default: head_mod = head;
      endcase
    end
    if (add_here) begin
      head_mod        = '0;
      head_mod.id     = id_r;
      head_mod.weight = wt_r;
    end
  end

  // Share of the head entry in the final pass.
  always_comb begin
    sh9        = {1'b0, head.quot} + 9'((9'(head.ahead) < rem_r) ? 1 : 0);
    head_share = (sh9 == 9'd0) ? 8'd1 : sh9[7:0];
  end

  // Start admission, yield advice and earliest start.
  always_comb begin
    cap      = (TW'(budget_r) > TW'(count_r)) ? TW'(budget_r) : TW'(count_r);
    too_soon = seen_r && ((now_r < last_time_r) ||
                          ((now_r - last_time_r) < {16'd0, stagger_r}));
    allowed  = found2_r && !(actsum_r >= cap) && !too_soon &&
               ((usr_act_r < usr_share_r) || !starved_r);
    yld      = found2_r && (usr_act_r > usr_share_r) && starved_r;
    e49      = {1'b0, last_time_r} + {17'd0, stagger_r};
    esat     = e49[48] ? 48'hFFFF_FFFF_FFFF : e49[47:0];
    earliest = !seen_r ? now_r : ((now_r > esat) ? now_r : esat);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_SCAN;
      S_SCAN:     if (k_last) state_nxt = S_APPLY;
      S_APPLY:    state_nxt = S_RANK_CLR;
      S_RANK_CLR: state_nxt = S_RANK;
      S_RANK:     if (k_last) state_nxt = S_DIV_MUL;
      S_DIV_MUL: begin
        if (k_valid) state_nxt = S_DIV_GO;
        else if (k_last) state_nxt = S_REMAIN;
      end
      S_DIV_GO:   state_nxt = S_DIV_RUN;
      S_DIV_RUN: begin
        if (div_done) state_nxt = k_last ? S_REMAIN : S_DIV_MUL;
      end
      S_REMAIN:   state_nxt = S_FINAL;
      S_FINAL:    if (k_last) state_nxt = S_OUT;
      S_OUT:      if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Ring and divider controls.
  always_comb begin
    ring_shift   = 1'b0;
    compact      = 1'b0;
    ctl          = '0;
    hbc          = '0;
    feed         = head;
    div_start    = 1'b0;
    case (state_r)
      S_SCAN: begin
        ring_shift = 1'b1;
        feed       = head_mod;
      end
      S_APPLY:    compact = (op_r == OP_REMOVE) && found_r;
      S_RANK_CLR: ctl.rank_clr = 1'b1;
      S_RANK: begin
        ring_shift  = 1'b1;
        ctl.rank_en = 1'b1;
        hbc.valid   = k_valid;
        hbc.weight  = head.weight;
        feed        = pass_arr[0];
      end
      S_DIV_MUL:  ring_shift = !k_valid;
      S_DIV_GO:   div_start = 1'b1;
      S_DIV_RUN: begin
        ring_shift = div_done;
        feed.quot  = div_quot[7:0];
      end
      S_FINAL:    ring_shift = 1'b1;
      default:    ring_shift = 1'b0;
    endcase
  end

  // Control state and table bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      count_r       <= '0;
      budget_r      <= RESET_BUDGET;
      stagger_r     <= '0;
      last_time_r   <= '0;
      seen_r        <= 1'b0;
      k_r           <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      // Configuration writes.
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_INITIAL_BUDGET: begin
            budget_r <= (cfg_data[7:0] == 8'd0) ? 8'd1 : cfg_data[7:0];
          end
          CFG_STAGGER: stagger_r <= cfg_data;
          default: stagger_r <= stagger_r;
        endcase
      end

      // Position counter for the ring passes.
      if (ring_shift) k_r <= k_last ? '0 : k_r + 1'b1;

      // Table-wide effects of the request.
      if (state_r == S_APPLY) begin
        if (add_done_r) count_r <= count_r + 1'b1;
        if ((op_r == OP_REMOVE) && found_r) count_r <= count_r - 1'b1;
        if ((op_r == OP_STARTED) && found_r) begin
          last_time_r <= now_r;
          seen_r      <= 1'b1;
        end
        if ((op_r == OP_REFUSED) && !((actsum_r < TW'(2)) || (budget_r <= 8'd1)))
          budget_r <= budget_r - 8'd1;
      end

      if ((state_r == S_OUT) && out_free) out_valid_r <= 1'b1;
    end
  end

  // Request datapath.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        op_r       <= op_t'(in_op);
        id_r       <= in_user_id;
        wt_r       <= (in_weight == 8'd0) ? 8'd1 : in_weight;
        delta_r    <= in_waiting_delta;
        now_r      <= in_now;
        found_r    <= 1'b0;
        add_done_r <= 1'b0;
        actsum_r   <= '0;
      end
      S_SCAN: begin
        if (scan_hit) begin
          found_r <= 1'b1;
          idx_r   <= k_r;
        end
        if (add_here) add_done_r <= 1'b1;
        if (k_valid) actsum_r <= actsum_r + TW'(head.active);
      end
      S_APPLY: begin
        case (op_r)
          OP_ADD:     status_r <= (!found_r && !add_done_r) ? ST_FULL : ST_OK;
          OP_REFUSED: status_r <= ((actsum_r < TW'(2)) || (budget_r <= 8'd1)) ?
                                  ST_DECLINED : ST_OK;
          default:    status_r <= found_r ? ST_OK : ST_NO_USER;
        endcase
      end
      S_RANK_CLR: begin
        tsum_r   <= '0;
        actsum_r <= '0;
        found2_r <= 1'b0;
        given_r  <= '0;
      end
      S_RANK: begin
        if (k_valid) begin
          tsum_r   <= tsum_r + TW'(head.weight);
          actsum_r <= actsum_r + TW'(head.active);
          if ((head.id == id_r) && !found2_r) begin
            found2_r <= 1'b1;
            idx2_r   <= k_r;
          end
        end
      end
      S_DIV_MUL: prod_r <= budget_r * head.weight;
      S_DIV_RUN: begin
        if (div_done) given_r <= given_r + {1'b0, div_quot[7:0]};
      end
      S_REMAIN: begin
        rem_r       <= ({1'b0, budget_r} > given_r) ? ({1'b0, budget_r} - given_r) : 9'd0;
        starved_r   <= 1'b0;
        usr_share_r <= '0;
        usr_act_r   <= '0;
      end
      S_FINAL: begin
        if (k_valid) begin
          if (found2_r && (k_r == idx2_r)) begin
            usr_share_r <= head_share;
            usr_act_r   <= head.active;
          end else if ((head.waiting != 16'd0) && (head.active < head_share)) begin
            starved_r <= 1'b1;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          o_status_r   <= status_r;
          o_share_r    <= usr_share_r;
          o_active_r   <= usr_act_r;
          o_all_r      <= (actsum_r > TW'(4095)) ? 12'hFFF : actsum_r[11:0];
          o_budget_r   <= budget_r;
          o_allowed_r  <= allowed;
          o_yield_r    <= yld;
          o_earliest_r <= earliest;
          o_total_r    <= (count_r > CW'(31)) ? 5'd31 : 5'(count_r);
        end
      end
      default: prod_r <= prod_r;
    endcase
  end

  assign in_stall           = state_r != S_IDLE;
  assign out_valid          = out_valid_r;
  assign out_status         = o_status_r;
  assign out_user_share     = o_share_r;
  assign out_user_active    = o_active_r;
  assign out_all_active     = o_all_r;
  assign out_current_budget = o_budget_r;
  assign out_start_allowed  = o_allowed_r;
  assign out_yield_advised  = o_yield_r;
  assign out_earliest_start = o_earliest_r;
  assign out_user_total     = o_total_r;

endmodule

>>> hw/rtl/wcsa_checker.sv
// ----------------------------------------------------------------------------
// Weighted connection share arbiter checker
// Port-level properties of the arbiter, bound to the top level.
// ----------------------------------------------------------------------------
`include "weighted_connection_share_arbiter_top_defines.svh"

module wcsa_checker import wcsa_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [7:0]  out_user_share,
  input logic [7:0]  out_user_active,
  input logic [7:0]  out_current_budget,
  input logic        out_start_allowed,
  input logic        out_yield_advised,
  input logic [47:0] out_earliest_start
);

  // A stalled result stays offered and unchanged.
  `WCSA_CHECK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_earliest_start) && $stable(out_user_share))

  // An accepted request keeps the sequencer busy in the next cycle.
  `WCSA_CHECK_NEXT(a_busy_after_req, clk, rst_n, in_valid && !in_stall, in_stall)

  // An unknown user shows no share, no connections and no advice.
  `WCSA_CHECK_SAME(a_absent_user, clk, rst_n, out_valid && (out_status == ST_NO_USER), (out_user_share == 8'd0) && (out_user_active == 8'd0) && !out_start_allowed && !out_yield_advised)

  // Start and yield never both advised, and the budget never reaches zero.
  `WCSA_CHECK_SAME(a_advice_budget, clk, rst_n, out_valid, !(out_start_allowed && out_yield_advised) && (out_current_budget != 8'd0))

endmodule

bind weighted_connection_share_arbiter_top wcsa_checker u_wcsa_checker (.*);

>>> tb/wcsa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted connection share arbiter: result checker
// Watches the request and result channels, keeps its own copy of the user
// table and budget, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module wcsa_scoreboard import wcsa_pkg::*; #(
  parameter int MAX_USERS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [7:0]  in_user_id,
  input  logic [7:0]  in_weight,
  input  logic signed [7:0] in_waiting_delta,
  input  logic [47:0] in_now,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_status,
  input  logic [7:0]  out_user_share,
  input  logic [7:0]  out_user_active,
  input  logic [11:0] out_all_active,
  input  logic [7:0]  out_current_budget,
  input  logic        out_start_allowed,
  input  logic        out_yield_advised,
  input  logic [47:0] out_earliest_start,
  input  logic [4:0]  out_user_total,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    logic [1:0]  status;
    logic [7:0]  share;
    logic [7:0]  active;
    logic [11:0] all;
    logic [7:0]  budget;
    logic        allowed;
    logic        yield_adv;
    logic [47:0] earliest;
    logic [4:0]  total;
  } outcome_t;

  // Shadow state of the arbiter.
  logic [7:0]  ids     [MAX_USERS];
  logic [7:0]  weights [MAX_USERS];
  logic [7:0]  actives [MAX_USERS];
  logic [15:0] waits   [MAX_USERS];
  int          users;
  int          budget;
  logic [47:0] last_start;
  logic        start_seen;
  logic [31:0] stagger;
  outcome_t    awaited[$];

  function automatic int find_user(input logic [7:0] id);
    for (int i = 0; i < users; i++) if (ids[i] == id) return i;
    return -1;
  endfunction

  function automatic int active_sum();
    int s;
    s = 0;
    for (int i = 0; i < users; i++) s += actives[i];
    return s;
  endfunction

  // Floor share plus one remainder connection by weight rank, then age.
  function automatic int fair_share(input int idx);
    int tw, given, rem, ahead, base;
    tw = 0; given = 0; ahead = 0;
    for (int i = 0; i < users; i++) tw += weights[i];
    if (tw == 0) return 1;
    for (int i = 0; i < users; i++) given += budget * weights[i] / tw;
    rem = budget > given ? budget - given : 0;
    for (int i = 0; i < users; i++)
      if (weights[i] > weights[idx] || (weights[i] == weights[idx] && i < idx)) ahead++;
    base = budget * weights[idx] / tw + (ahead < rem ? 1 : 0);
    return base < 1 ? 1 : base;
  endfunction

  function automatic bit someone_starved(input int idx);
    for (int i = 0; i < users; i++)
      if (i != idx && waits[i] > 0 && actives[i] < fair_share(i)) return 1;
    return 0;
  endfunction

  // Apply one request to the shadow table and return its expected result.
  function automatic outcome_t apply_request(input op_t op, input logic [7:0] id,
                                             input logic [7:0] w_in,
                                             input logic signed [7:0] delta,
                                             input logic [47:0] now);
    outcome_t r;
    int idx, v, cap, all, sh;
    logic [7:0] w;
    logic [48:0] ear;
    bit starved;
    r = '{default: '0};
    w = (w_in == 0) ? 8'd1 : w_in;
    idx = find_user(id);
    r.status = ST_OK;
    case (op)
      OP_ADD: begin
        if (idx < 0) begin
          if (users >= MAX_USERS) r.status = ST_FULL;
          else begin
            ids[users] = id; weights[users] = w; actives[users] = 0; waits[users] = 0;
            users++;
          end
        end
      end
      OP_SET_WEIGHT: begin
        if (idx < 0) r.status = ST_NO_USER; else weights[idx] = w;
      end
      OP_REMOVE: begin
        if (idx < 0) r.status = ST_NO_USER;
        else begin
          for (int i = idx; i + 1 < users; i++) begin
            ids[i] = ids[i+1]; weights[i] = weights[i+1];
            actives[i] = actives[i+1]; waits[i] = waits[i+1];
          end
          users--;
        end
      end
      OP_ADJUST_WAIT: begin
        if (idx < 0) r.status = ST_NO_USER;
        else begin
          v = int'(waits[idx]) + int'(delta);
          if (v < 0) v = 0;
          if (v > 65535) v = 65535;
          waits[idx] = v[15:0];
        end
      end
      OP_STARTED: begin
        if (idx < 0) r.status = ST_NO_USER;
        else begin
          if (actives[idx] < 255) actives[idx]++;
          last_start = now; start_seen = 1;
        end
      end
      OP_FINISHED: begin
        if (idx < 0) r.status = ST_NO_USER;
        else if (actives[idx] > 0) actives[idx]--;
      end
      OP_REFUSED: begin
        if (active_sum() < 2 || budget <= 1) r.status = ST_DECLINED;
        else budget--;
      end
      default: begin
        if (idx < 0) r.status = ST_NO_USER;
      end
    endcase
    idx = find_user(id);
    all = active_sum();
    if (idx >= 0) begin
      cap = budget > users ? budget : users;
      starved = someone_starved(idx);
      sh = fair_share(idx);
      r.share = sh[7:0];
      r.active = actives[idx];
      r.allowed = 1;
      if (all >= cap) r.allowed = 0;
      if (start_seen && (now < last_start || now - last_start < {16'd0, stagger}))
        r.allowed = 0;
      if (r.allowed && !(actives[idx] < sh || !starved)) r.allowed = 0;
      r.yield_adv = (actives[idx] > sh) && starved;
    end
    if (!start_seen) r.earliest = now;
    else begin
      ear = {1'b0, last_start} + {17'd0, stagger};
      if (ear[48]) ear = {1'b0, {48{1'b1}}};
      if ({1'b0, now} > ear) ear = {1'b0, now};
      r.earliest = ear[47:0];
    end
    r.all = all > 4095 ? 12'hFFF : all[11:0];
    r.budget = budget[7:0];
    r.total = users > 31 ? 5'd31 : users[4:0];
    return r;
  endfunction

  // Track configuration and requests; check results against the oldest prediction.
  always @(posedge clk) begin
    outcome_t e;
    if (!rst_n) begin
      users = 0; budget = RESET_BUDGET; last_start = '0; start_seen = 0;
      stagger = '0; awaited.delete(); fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_INITIAL_BUDGET)
          budget = (cfg_data[7:0] == 0) ? 1 : cfg_data[7:0];
        else if (cfg_index == CFG_STAGGER) stagger = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (awaited.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          e = awaited.pop_front();
          if (out_status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_status); fail_count++;
          end
          if (out_user_share !== e.share) begin
            $error("user_share exp %0d got %0d", e.share, out_user_share); fail_count++;
          end
          if (out_user_active !== e.active) begin
            $error("user_active exp %0d got %0d", e.active, out_user_active); fail_count++;
          end
          if (out_all_active !== e.all) begin
            $error("all_active exp %0d got %0d", e.all, out_all_active); fail_count++;
          end
          if (out_current_budget !== e.budget) begin
            $error("current_budget exp %0d got %0d", e.budget, out_current_budget);
            fail_count++;
          end
          if (out_start_allowed !== e.allowed) begin
            $error("start_allowed exp %0d got %0d", e.allowed, out_start_allowed);
            fail_count++;
          end
          if (out_yield_advised !== e.yield_adv) begin
            $error("yield_advised exp %0d got %0d", e.yield_adv, out_yield_advised);
            fail_count++;
          end
          if (out_earliest_start !== e.earliest) begin
            $error("earliest_start exp %0d got %0d", e.earliest, out_earliest_start);
            fail_count++;
          end
          if (out_user_total !== e.total) begin
            $error("user_total exp %0d got %0d", e.total, out_user_total); fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        e = apply_request(op_t'(in_op), in_user_id, in_weight, in_waiting_delta, in_now);
        awaited.insert(awaited.size(), e);
      end
    end
    pending = awaited.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted connection share arbiter testbench
// Directed and random requests with random idling on both channels and
// several budget and stagger settings; the checker predicts every result.
// ----------------------------------------------------------------------------
module tb import wcsa_pkg::*; ();

  localparam int MAX_USERS = 16;
  localparam int PHASE_REQS = 250;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_op;
  logic [7:0]  in_user_id;
  logic [7:0]  in_weight;
  logic signed [7:0] in_waiting_delta;
  logic [47:0] in_now;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [7:0]  out_user_share;
  logic [7:0]  out_user_active;
  logic [11:0] out_all_active;
  logic [7:0]  out_current_budget;
  logic        out_start_allowed;
  logic        out_yield_advised;
  logic [47:0] out_earliest_start;
  logic [4:0]  out_user_total;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_data;
  int          fail_count;
  int          pending;
  logic [47:0] tick;
  bit          calm;

  weighted_connection_share_arbiter_top #(.MAX_USERS(MAX_USERS)) i_dut (.*);
  wcsa_scoreboard #(.MAX_USERS(MAX_USERS)) i_checker (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("TB_ERROR");
    $finish;
  end

  // Result side stalls in random bursts, except in the calm final stretch.
  initial begin
    out_stall = 0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  // Present one request and hold it until accepted.
  task automatic send(input op_t op, input logic [7:0] id, input logic [7:0] w,
                      input logic [7:0] d, input logic [47:0] now);
    in_valid <= 1; in_op <= op; in_user_id <= id; in_weight <= w;
    in_waiting_delta <= d; in_now <= now;
    do @(posedge clk); while (in_stall);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // Wait for all results, then let the block settle.
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // Mostly known ids so that requests reach the table; time mostly advances.
  task automatic random_request();
    op_t op;
    logic [7:0] id;
    op = op_t'($urandom_range(0, 7));
    id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 19));
    if ($urandom_range(0, 15) == 0) tick = tick - $urandom_range(0, 50);
    else tick = tick + $urandom_range(0, 40);
    send(op, id, ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom),
         8'($urandom), tick);
  endtask

  initial begin
    rst_n = 0; in_valid = 0; in_op = OP_QUERY; in_user_id = 0; in_weight = 0;
    in_waiting_delta = 0; in_now = 0; cfg_we = 0; cfg_index = CFG_INITIAL_BUDGET;
    cfg_data = 0; tick = 48'd1000; calm = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: every operation, table full, unknown users, refusals, extremes.
    send(OP_QUERY, 8'd5, 8'd0, 8'd0, 48'd0);
    send(OP_REFUSED, 8'd0, 8'd0, 8'd0, 48'd1);
    for (int i = 0; i < MAX_USERS; i++)
      send(OP_ADD, (i == 0) ? 8'hFF : 8'(i), (i == 1) ? 8'hFF : 8'(i), 8'd0, 48'd2);
    send(OP_ADD, 8'd200, 8'd3, 8'd0, 48'd3);
    send(OP_ADD, 8'd1, 8'd9, 8'd0, 48'd3);
    send(OP_SET_WEIGHT, 8'd2, 8'd0, 8'd0, 48'd4);
    send(OP_ADJUST_WAIT, 8'd3, 8'd0, 8'h7F, 48'd5);
    send(OP_ADJUST_WAIT, 8'd4, 8'd0, 8'h80, 48'd5);
    send(OP_STARTED, 8'd1, 8'd0, 8'd0, 48'hFFFF_FFFF_FFFF);
    send(OP_STARTED, 8'd5, 8'd0, 8'd0, 48'd10);
    send(OP_QUERY, 8'd3, 8'd0, 8'd0, 48'd5);
    send(OP_REFUSED, 8'd77, 8'd0, 8'd0, 48'd11);
    send(OP_FINISHED, 8'd6, 8'd0, 8'd0, 48'd12);
    send(OP_REMOVE, 8'hFF, 8'd0, 8'd0, 48'd13);
    send(OP_REMOVE, 8'd99, 8'd0, 8'd0, 48'd13);
    drain();

    // Random phases over budget and stagger settings, extremes included.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin write_reg(CFG_INITIAL_BUDGET, 32'd255); write_reg(CFG_STAGGER, 32'hFFFF_FFFF); end
        1: begin write_reg(CFG_INITIAL_BUDGET, 32'd0); write_reg(CFG_STAGGER, 32'd0); end
        2: begin write_reg(CFG_INITIAL_BUDGET, 32'd1); write_reg(CFG_STAGGER, 32'd20); end
        default: begin
          write_reg(CFG_INITIAL_BUDGET, 32'($urandom_range(2, 40)));
          write_reg(CFG_STAGGER, 32'($urandom_range(0, 60)));
        end
      endcase
      if (ph == 3) calm = 1;
      for (int n = 0; n < PHASE_REQS; n++) begin
        random_request();
        if (ph == 1 && n == 100) begin
          in_valid <= 0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
      end
      drain();
    end

    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

>>> weighted_connection_share_arbiter_top.f
+incdir+hw/rtl
hw/rtl/wcsa_pkg.sv
hw/rtl/wcsa_cell.sv
hw/rtl/wcsa_div.sv
hw/rtl/weighted_connection_share_arbiter_top.sv
hw/rtl/wcsa_checker.sv
tb/wcsa_checker.sv
tb/tb.sv
